// ----- src/sam_pkg.sv -----
// sam_pkg: shared types, codes and constants of the stepper angle microstepper
// holds the quarter-wave sine table and its lookup functions
// no dependencies
package sam_pkg;

  localparam logic [1:0] REQ_ANGLE = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_ZERO  = 2'd2;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWM_TOP  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEPS_Q8 = 8'd1;

  localparam logic [15:0] PWM_TOP_RESET  = 16'd1000;
  localparam logic [15:0] STEPS_Q8_RESET = 16'd256;

  localparam int PHASE_STEPS_DEF = 128;
  localparam int DUTY_BITS_DEF   = 16;
  localparam int PHASE_W_MAX     = 10;
  localparam int QUEUE_DEPTH     = 4;

  localparam int FULL_TURN       = 360;
  localparam int HALF_TURN       = 180;
  localparam logic [14:0] STEP_SAT = 15'h7FFF;
  // floor(x/360) = (x * RECIP_360) >> 24, exact for every 16-bit x
  localparam logic [15:0] RECIP_360 = 16'd46604;
  localparam int RECIP_360_SHIFT = 24;

  localparam logic [14:0] QUARTER_WAVE [33] = '{
    15'd0,     15'd1608,  15'd3212,  15'd4808,  15'd6393,  15'd7962,  15'd9512,
    15'd11039, 15'd12540, 15'd14010, 15'd15447, 15'd16846, 15'd18205, 15'd19520,
    15'd20788, 15'd22006, 15'd23170, 15'd24279, 15'd25330, 15'd26320, 15'd27245,
    15'd28106, 15'd28899, 15'd29622, 15'd30274, 15'd30853, 15'd31357, 15'd31786,
    15'd32138, 15'd32413, 15'd32610, 15'd32729, 15'd32767
  };

  typedef struct packed {
    logic                   kind;
    logic                   accepted;
    logic [PHASE_W_MAX-1:0] phase;
    logic [14:0]            remaining;
    logic                   done;
  } entry_t;

  // magnitude of the Q1.15 sine at table index 0..127
  function automatic logic [14:0] wave_mag(input logic [6:0] idx);
    logic [1:0] quad;
    logic [5:0] r;
    quad = idx[6:5];
    r    = {1'b0, idx[4:0]};
    if (quad == 2'd0 || quad == 2'd2) begin
      wave_mag = QUARTER_WAVE[r];
    end else begin
      wave_mag = QUARTER_WAVE[6'd32 - r];
    end
  endfunction

  // sine strictly positive at table index 0..127
  function automatic logic wave_pos(input logic [6:0] idx);
    wave_pos = (idx[6] == 1'b0) && (idx != 7'd0);
  endfunction

endpackage

// ----- src/sam_front.sv -----
// sam_front: accepts requests, reduces angles modulo 360 and owns the move state
// writes command acknowledges and microstep orders into the queue; uses sam_pkg
module sam_front
  import sam_pkg::*;
#(
  parameter int PHASE_STEPS = PHASE_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req,
  input  logic [15:0] in_angle,
  input  logic [15:0] steps_q8,
  input  logic        q_full,
  output logic        q_wr,
  output entry_t      q_wr_data
);

  localparam int PW = $clog2(PHASE_STEPS);

  // stage 1: reciprocal product for the modulo
  logic        s1_valid;
  logic [1:0]  s1_req;
  logic [15:0] s1_angle;
  logic [7:0]  s1_quot;
  // stage 2: reduced angle
  logic        s2_valid;
  logic [1:0]  s2_req;
  logic [8:0]  s2_angle;

  logic [8:0]    position_deg;
  logic [PW-1:0] phase_index;
  logic [14:0]   pending_steps;
  logic          reverse_dir;

  logic [8:0]    position_deg_next;
  logic [PW-1:0] phase_index_next;
  logic [14:0]   pending_steps_next;
  logic          reverse_dir_next;

  logic          emit;
  logic          s2_go;
  logic          s2_ready;
  logic [31:0]   recip_prod;
  logic [16:0]   mod_rem;
  logic signed [10:0] delta;
  logic [10:0]   delta_abs;
  logic [23:0]   steps_prod;
  logic [15:0]   steps_raw;
  logic [14:0]   steps_sat;
  logic [14:0]   pending_dec;
  logic [PW:0]   phase_inc;
  entry_t        entry;

  assign recip_prod = 32'(in_angle) * 32'(RECIP_360);
  assign mod_rem    = 17'(s1_angle) - 17'(s1_quot) * 17'(FULL_TURN);

  assign emit     = (s2_req == REQ_ANGLE) || ((s2_req == REQ_TICK) && (pending_steps != 15'd0));
  assign s2_go    = s2_valid && (!emit || !q_full);
  assign s2_ready = !s2_valid || s2_go;
  assign in_ready = !s1_valid || s2_ready;

  always_comb begin
    delta = $signed({2'b00, s2_angle}) - $signed({2'b00, position_deg});
    if (delta > 11'(HALF_TURN)) begin
      delta = delta - 11'(FULL_TURN);
    end else if (delta < -11'(HALF_TURN)) begin
      delta = delta + 11'(FULL_TURN);
    end
    delta_abs  = (delta < 0) ? 11'(-delta) : 11'(delta);
    steps_prod = 24'(delta_abs[7:0]) * 24'(steps_q8);
    steps_raw  = steps_prod[23:8];
    steps_sat  = (steps_raw > 16'(STEP_SAT)) ? STEP_SAT : steps_raw[14:0];
    pending_dec = pending_steps - 15'd1;
    phase_inc  = {1'b0, phase_index} + {{PW{1'b0}}, 1'b1};

    position_deg_next  = position_deg;
    phase_index_next   = phase_index;
    pending_steps_next = pending_steps;
    reverse_dir_next   = reverse_dir;

    entry.kind      = KIND_ACK;
    entry.accepted  = 1'b0;
    entry.phase     = PHASE_W_MAX'(phase_index);
    entry.remaining = pending_steps;
    entry.done      = 1'b0;

    case (s2_req)
      REQ_ANGLE: begin
        if (pending_steps == 15'd0) begin
          position_deg_next  = s2_angle;
          pending_steps_next = steps_sat;
          reverse_dir_next   = (delta < 0) && (steps_sat != 15'd0);
          entry.accepted     = 1'b1;
          entry.remaining    = steps_sat;
          entry.done         = (steps_sat == 15'd0);
        end
      end
      REQ_TICK: begin
        if (pending_steps != 15'd0) begin
          if (reverse_dir) begin
            phase_index_next = (phase_index == '0) ? PW'(PHASE_STEPS - 1) : phase_index - 1'b1;
          end else begin
            phase_index_next = (phase_inc >= (PW+1)'(PHASE_STEPS)) ? '0 : phase_inc[PW-1:0];
          end
          pending_steps_next = pending_dec;
          entry.kind         = KIND_STEP;
          entry.accepted     = 1'b1;
          entry.remaining    = pending_dec;
          entry.done         = (pending_dec == 15'd0);
        end
      end
      REQ_ZERO: begin
        position_deg_next = 9'd0;
      end
      default: begin
      end
    endcase
  end

  assign q_wr      = s2_go && emit;
  assign q_wr_data = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      position_deg  <= '0;
      phase_index   <= '0;
      pending_steps <= '0;
      reverse_dir   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s2_go) begin
        position_deg  <= position_deg_next;
        phase_index   <= phase_index_next;
        pending_steps <= pending_steps_next;
        reverse_dir   <= reverse_dir_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_req   <= in_req;
      s1_angle <= in_angle;
      s1_quot  <= recip_prod[RECIP_360_SHIFT+7:RECIP_360_SHIFT];
    end
    if (s2_ready) begin
      s2_req   <= s1_req;
      s2_angle <= mod_rem[8:0];
    end
  end

endmodule

// ----- src/sam_queue.sv -----
// sam_queue: short first-in first-out queue between front and back
// holds entry_t items; uses sam_pkg
module sam_queue
  import sam_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_data,
  input  logic   rd,
  output entry_t rd_data,
  output logic   full,
  output logic   empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t        mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full    = (count == (AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- src/sam_back.sv -----
// sam_back: turns queued items into results, sine/cosine lookup and coil duty scaling
// ends in the output register of the result stream; uses sam_pkg
module sam_back
  import sam_pkg::*;
#(
  parameter int PHASE_STEPS = PHASE_STEPS_DEF,
  parameter int DUTY_BITS   = DUTY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] pwm_top,
  input  logic        q_empty,
  output logic        q_rd,
  input  entry_t      q_rd_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic        out_accepted,
  output logic [15:0] out_coil_a,
  output logic [15:0] out_coil_b,
  output logic [3:0]  out_pattern,
  output logic [6:0]  out_phase,
  output logic [14:0] out_remaining,
  output logic        out_done
);

  // table index = phase * 128 / PHASE_STEPS = (phase * IDX_RECIP) >> 20
  localparam int IDX_SHIFT = 27;
  localparam longint unsigned IDX_RECIP =
    ((longint'(1) << IDX_SHIFT) + PHASE_STEPS - 1) / PHASE_STEPS;
  localparam logic [16:0] DUTY_LIM = 17'((1 << DUTY_BITS) - 1);

  logic        b1_valid;
  entry_t      b1_entry;
  logic [6:0]  b1_idx;
  logic        b1_ready;
  logic        b2_ready;

  logic [35:0] idx_prod;
  logic [6:0]  cos_idx;
  logic [14:0] sin_mag;
  logic [14:0] cos_mag;
  logic [15:0] scale;
  logic [30:0] duty_a_prod;
  logic [30:0] duty_b_prod;
  logic [15:0] duty_a;
  logic [15:0] duty_b;

  assign b2_ready = !out_valid || out_ready;
  assign b1_ready = !b1_valid || b2_ready;
  assign q_rd     = !q_empty && b1_ready;

  assign idx_prod = 36'(q_rd_data.phase) * 36'(IDX_RECIP);

  always_comb begin
    cos_idx     = b1_idx + 7'd32;
    sin_mag     = wave_mag(b1_idx);
    cos_mag     = wave_mag(cos_idx);
    scale       = (pwm_top == 16'd0) ? 16'd0 : pwm_top - 16'd1;
    duty_a_prod = 31'(scale) * 31'(sin_mag);
    duty_b_prod = 31'(scale) * 31'(cos_mag);
    duty_a      = ({1'b0, duty_a_prod[30:15]} > DUTY_LIM) ? DUTY_LIM[15:0] : duty_a_prod[30:15];
    duty_b      = ({1'b0, duty_b_prod[30:15]} > DUTY_LIM) ? DUTY_LIM[15:0] : duty_b_prod[30:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid <= q_rd;
      end
      if (b2_ready) begin
        out_valid <= b1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_ready) begin
      b1_entry <= q_rd_data;
      b1_idx   <= idx_prod[IDX_SHIFT-1:IDX_SHIFT-7];
    end
    if (b2_ready) begin
      out_kind      <= b1_entry.kind;
      out_accepted  <= b1_entry.accepted;
      out_phase     <= 7'(b1_entry.phase);
      out_remaining <= b1_entry.remaining;
      out_done      <= b1_entry.done;
      if (b1_entry.kind == KIND_STEP) begin
        out_coil_a  <= duty_a;
        out_coil_b  <= duty_b;
        out_pattern <= {!wave_pos(cos_idx), wave_pos(cos_idx),
                        !wave_pos(b1_idx), wave_pos(b1_idx)};
      end else begin
        out_coil_a  <= 16'd0;
        out_coil_b  <= 16'd0;
        out_pattern <= 4'd0;
      end
    end
  end

endmodule

// ----- src/stepper_angle_microstepper_top.sv -----
// stepper angle microstepper: one request per cycle and throughput of one item per cycle,
// both while m_tready keeps up; the state update stage sets the pace (one multiply)
// front: modulo and move state, queue of four items, back: table lookup and duty multiply
// rst is synchronous: clears the move state and loads register defaults, no clearing pass
// uses sam_pkg, sam_front, sam_queue, sam_back
module stepper_angle_microstepper_top
  import sam_pkg::*;
#(
  parameter int PHASE_STEPS = PHASE_STEPS_DEF,
  parameter int DUTY_BITS   = DUTY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // target_angle
  input  logic [1:0]             s_tuser,   // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // accepted, coil_a_duty, coil_b_duty, drive_pattern, phase_out, steps_remaining, zero fill
  output logic [63:0]            m_tdata,
  output logic                   m_tuser,   // result_kind
  output logic                   m_tlast,   // move_done
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  logic [15:0] pwm_top;
  logic [15:0] steps_per_degree_q8;

  logic        q_wr;
  entry_t      q_wr_data;
  logic        q_rd;
  entry_t      q_rd_data;
  logic        q_full;
  logic        q_empty;

  logic        out_accepted;
  logic [15:0] out_coil_a;
  logic [15:0] out_coil_b;
  logic [3:0]  out_pattern;
  logic [6:0]  out_phase;
  logic [14:0] out_remaining;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_top             <= PWM_TOP_RESET;
      steps_per_degree_q8 <= STEPS_Q8_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PWM_TOP:  pwm_top             <= cfg_data;
        CFG_STEPS_Q8: steps_per_degree_q8 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sam_front #(
    .PHASE_STEPS(PHASE_STEPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_angle  (s_tdata),
    .steps_q8  (steps_per_degree_q8),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data)
  );

  sam_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  sam_back #(
    .PHASE_STEPS(PHASE_STEPS),
    .DUTY_BITS  (DUTY_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pwm_top       (pwm_top),
    .q_empty       (q_empty),
    .q_rd          (q_rd),
    .q_rd_data     (q_rd_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_kind      (m_tuser),
    .out_accepted  (out_accepted),
    .out_coil_a    (out_coil_a),
    .out_coil_b    (out_coil_b),
    .out_pattern   (out_pattern),
    .out_phase     (out_phase),
    .out_remaining (out_remaining),
    .out_done      (m_tlast)
  );

  assign m_tdata = {5'd0, out_remaining, out_phase, out_pattern,
                    out_coil_b, out_coil_a, out_accepted};

endmodule

// ----- verif/stepper_angle_microstepper_checker.sv -----
// checker for the stepper angle microstepper: watches the request, result and register channels
// predicts each result from its own copy of the move state and compares field by field
// depends on sam_pkg for request, result kind and register codes
module stepper_angle_microstepper_checker
  import sam_pkg::*;
#(
  parameter int PHASE_STEPS = PHASE_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [15:0]            s_tdata,
  input  logic [1:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [63:0]            m_tdata,
  input  logic                   m_tuser,
  input  logic                   m_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  output int                     fail_count,
  output int                     outstanding,
  output int                     move_pending,
  output int                     position,
  output int                     ack_count,
  output int                     busy_count,
  output int                     step_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEG_TURN  = 360;
  localparam int DEG_HALF  = 180;
  localparam int STEPS_MAX = 32767;
  localparam int WAVE_LEN  = 128;
  localparam int WAVE_QTR  = 32;
  localparam int MAX_PRINT = 40;

  localparam logic [14:0] SINE_QUARTER [33] = '{
    15'd0,     15'd1608,  15'd3212,  15'd4808,  15'd6393,  15'd7962,  15'd9512,
    15'd11039, 15'd12540, 15'd14010, 15'd15447, 15'd16846, 15'd18205, 15'd19520,
    15'd20788, 15'd22006, 15'd23170, 15'd24279, 15'd25330, 15'd26320, 15'd27245,
    15'd28106, 15'd28899, 15'd29622, 15'd30274, 15'd30853, 15'd31357, 15'd31786,
    15'd32138, 15'd32413, 15'd32610, 15'd32729, 15'd32767
  };

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [3:0]  pattern;
    logic [6:0]  phase;
    logic [14:0] remaining;
    logic        done;
  } microstep_t;

  logic [15:0] pwm_top_cfg  = PWM_TOP_RESET;
  logic [15:0] steps_q8_cfg = STEPS_Q8_RESET;
  int          pos_deg      = 0;
  int          phase_idx    = 0;
  int unsigned steps_left   = 0;
  logic        reverse      = 1'b0;
  microstep_t  due_results[$];
  int          fails = 0;
  int          acks = 0;
  int          busies = 0;
  int          steps = 0;

  function automatic int sine_q15(input int idx);
    int i, r, q, mag;
    i = idx % WAVE_LEN;
    r = i % WAVE_QTR;
    q = i / WAVE_QTR;
    mag = (q == 0 || q == 2) ? int'(SINE_QUARTER[r]) : int'(SINE_QUARTER[WAVE_QTR - r]);
    return (q >= 2) ? -mag : mag;
  endfunction

  function automatic logic [15:0] duty_for(input int v);
    longint unsigned scale, mag, d;
    scale = (pwm_top_cfg == 16'd0) ? 0 : longint'(pwm_top_cfg) - 1;
    mag = (v < 0) ? -v : v;
    d = (scale * mag) >> 15;
    return (d > 65535) ? 16'hFFFF : d[15:0];
  endfunction

  task automatic predict_drive(input logic [1:0] req, input logic [15:0] angle);
    microstep_t res;
    int a, delta, s, c, idx;
    int unsigned mag;
    logic sp, cp;
    res = '0;
    case (req)
      REQ_ANGLE: begin
        res.kind = KIND_ACK;
        acks++;
        if (steps_left != 0) begin
          busies++;
          res.accepted  = 1'b0;
          res.phase     = 7'(phase_idx);
          res.remaining = 15'(steps_left);
        end else begin
          a = int'(angle) % DEG_TURN;
          delta = a - pos_deg;
          if (delta > DEG_HALF) begin
            delta -= DEG_TURN;
          end else if (delta < -DEG_HALF) begin
            delta += DEG_TURN;
          end
          pos_deg = a;
          mag = (delta < 0) ? -delta : delta;
          mag = (mag * steps_q8_cfg) >> 8;
          if (mag > STEPS_MAX) begin
            mag = STEPS_MAX;
          end
          steps_left = mag;
          reverse = (delta < 0) && (mag != 0);
          res.accepted  = 1'b1;
          res.phase     = 7'(phase_idx);
          res.remaining = 15'(steps_left);
          res.done      = (steps_left == 0);
        end
        due_results.push_back(res);
      end
      REQ_TICK: begin
        if (steps_left != 0) begin
          idx = phase_idx * WAVE_LEN / PHASE_STEPS;
          s = sine_q15(idx);
          c = sine_q15(idx + WAVE_QTR);
          sp = (s > 0);
          cp = (c > 0);
          res.kind     = KIND_STEP;
          res.accepted = 1'b1;
          res.duty_a   = duty_for(s);
          res.duty_b   = duty_for(c);
          res.pattern  = {~cp, cp, ~sp, sp};
          res.phase    = 7'(phase_idx);
          if (reverse) begin
            phase_idx = (phase_idx == 0) ? PHASE_STEPS - 1 : phase_idx - 1;
          end else begin
            phase_idx = (phase_idx + 1 >= PHASE_STEPS) ? 0 : phase_idx + 1;
          end
          steps_left--;
          res.remaining = 15'(steps_left);
          res.done      = (steps_left == 0);
          steps++;
          due_results.push_back(res);
        end
      end
      REQ_ZERO: begin
        pos_deg = 0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report(input string field, input longint want, input longint got);
    fails++;
    if (fails <= MAX_PRINT) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic check_result;
    microstep_t want;
    if (due_results.size() == 0) begin
      report("result with nothing due", 0, 1);
    end else begin
      want = due_results.pop_front();
      if (want.kind !== m_tuser)              report("result_kind", want.kind, m_tuser);
      if (want.accepted !== m_tdata[0])       report("accepted", want.accepted, m_tdata[0]);
      if (want.duty_a !== m_tdata[16:1])      report("coil_a_duty", want.duty_a, m_tdata[16:1]);
      if (want.duty_b !== m_tdata[32:17])     report("coil_b_duty", want.duty_b, m_tdata[32:17]);
      if (want.pattern !== m_tdata[36:33])    report("drive_pattern", want.pattern, m_tdata[36:33]);
      if (want.phase !== m_tdata[43:37])      report("phase_out", want.phase, m_tdata[43:37]);
      if (want.remaining !== m_tdata[58:44])  report("steps_remaining", want.remaining,
                                                     m_tdata[58:44]);
      if (want.done !== m_tlast)              report("move_done", want.done, m_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pwm_top_cfg  = PWM_TOP_RESET;
      steps_q8_cfg = STEPS_Q8_RESET;
      pos_deg      = 0;
      phase_idx    = 0;
      steps_left   = 0;
      reverse      = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PWM_TOP:  pwm_top_cfg = cfg_data;
          CFG_STEPS_Q8: steps_q8_cfg = cfg_data;
          default: begin
          end
        endcase
      end
      if (m_tvalid && m_tready) begin
        check_result();
      end
      if (s_tvalid && s_tready) begin
        predict_drive(s_tuser, s_tdata);
      end
    end
    fail_count   <= fails;
    outstanding  <= due_results.size();
    move_pending <= steps_left;
    position     <= pos_deg;
    ack_count    <= acks;
    busy_count   <= busies;
    step_count   <= steps;
  end

endmodule

// ----- verif/stepper_angle_microstepper_top_tb.sv -----
// testbench top for the stepper angle microstepper: clock, reset, requests and register writes
// checking is done by stepper_angle_microstepper_checker; depends on sam_pkg and the block
module stepper_angle_microstepper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sam_pkg::*;

  localparam int DEG_TURN    = 360;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 100;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [63:0]            m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  int fail_count, outstanding, move_pending, position, ack_count, busy_count, step_count;
  int send_idle = 24;
  int recv_idle = 73;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;
  int items_sent = 0;
  int settings = 0;
  int cur_q8 = 256;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stepper_angle_microstepper_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stepper_angle_microstepper_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding), .move_pending(move_pending),
    .position(position), .ack_count(ack_count), .busy_count(busy_count),
    .step_count(step_count)
  );

  // result side: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(input logic [1:0] req, input logic [15:0] angle);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= angle;
    do @(posedge clk); while (!s_tready);
    if (req != REQ_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering items until every result is back, then let the pipeline empty
  task automatic settle;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] top_val, input logic [15:0] q8);
    settle();
    write_reg(CFG_PWM_TOP, top_val);
    write_reg(CFG_STEPS_Q8, q8);
    cur_q8 = q8;
    settings++;
  endtask

  task automatic set_idle(input int sender_pct, input int receiver_pct);
    send_idle = sender_pct;
    recv_idle <= receiver_pct;
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (move_pending != 0 && guard < 40000) begin
      send(REQ_TICK, 16'($urandom));
      guard++;
    end
  endtask

  // angle command a given number of degrees away, with random whole turns added
  task automatic move_by(input int delta);
    int a;
    a = (position + delta + 2 * DEG_TURN) % DEG_TURN;
    send(REQ_ANGLE, 16'(a + DEG_TURN * int'($urandom_range(181))));
  endtask

  task automatic random_segment(input int count, input bit midway_pause);
    int start, pick, delta, est, mag, n, i;
    start = items_sent;
    while (items_sent - start < count) begin
      if (midway_pause && items_sent - start >= count / 2) begin
        settle();
        midway_pause = 1'b0;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        drain();
        if ($urandom_range(99) < 85) begin
          delta = int'($urandom_range(50)) - 25;
        end else begin
          delta = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(182, 178));
        end
        move_by(delta);
        mag = (delta < 0) ? -delta : delta;
        if (mag > DEG_TURN / 2) begin
          mag = DEG_TURN - mag;
        end
        est = (mag * cur_q8) >> 8;
        n = est + int'($urandom_range(2));
        for (i = 0; i < n; i++) begin
          if (i < est && $urandom_range(99) < 4) begin
            send(REQ_ANGLE, 16'($urandom));
          end
          send(REQ_TICK, 16'($urandom));
        end
      end else if (pick < 78) begin
        send(REQ_ZERO, 16'($urandom));
      end else if (pick < 85) begin
        send(REQ_UNUSED, 16'($urandom));
      end else if (pick < 93) begin
        send(REQ_ANGLE, 16'($urandom));
      end else begin
        send(REQ_TICK, 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // register defaults: idle tick, unused request, phase wraps both ways, busy command
    send(REQ_TICK, 16'd0);
    send(REQ_UNUSED, 16'hFFFF);
    send(REQ_ANGLE, 16'd359);
    send(REQ_TICK, 16'hFFFF);
    send(REQ_ANGLE, 16'd1);
    repeat (2) send(REQ_TICK, 16'd0);
    send(REQ_ANGLE, 16'd1);
    send(REQ_ANGLE, 16'hFFFF);
    send(REQ_ANGLE, 16'd200);
    send(REQ_ZERO, 16'hFFFF);
    repeat (15) send(REQ_TICK, 16'd0);

    // half turn either way, smallest nonzero duty scale
    configure(16'd2, 16'd2);
    send(REQ_ANGLE, 16'd180);
    send(REQ_TICK, 16'd0);
    send(REQ_ANGLE, 16'd0);
    send(REQ_TICK, 16'd0);

    configure(16'd0, 16'd256);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    random_segment(70, 1'b0);
    configure(16'hFFFF, 16'd128);
    random_segment(70, 1'b1);

    set_idle(73, 24);
    configure(16'd1, 16'd64);
    random_segment(70, 1'b0);
    configure(16'($urandom_range(65535, 2)), 16'($urandom_range(512, 1)));
    random_segment(70, 1'b0);

    set_idle(0, 0);
    configure(16'($urandom_range(65535, 2)), 16'd0);
    random_segment(40, 1'b0);
    configure(16'($urandom_range(65535, 2)), 16'($urandom_range(300, 1)));
    random_segment(70, 1'b0);

    // receiver held off while ticks keep coming
    configure(16'd1000, 16'd256);
    drain();
    move_by(90);
    hold_requests <= hold_requests + 1;
    repeat (60) send(REQ_TICK, 16'($urandom));
    settle();
    drain();

    // saturated move, a few microsteps and a busy command, left running
    configure(16'hFFFF, 16'hFFFF);
    drain();
    send(REQ_ZERO, 16'd0);
    send(REQ_ANGLE, 16'd180);
    repeat (20) send(REQ_TICK, 16'($urandom));
    send(REQ_ANGLE, 16'd90);

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests under %0d register settings, with sender and receiver stalls,",
             items_sent, settings);
    $display("a held-off receiver and a saturated move: %0d acks (%0d busy), %0d microsteps",
             ack_count, busy_count, step_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/sam_pkg.sv
src/sam_front.sv
src/sam_queue.sv
src/sam_back.sv
src/stepper_angle_microstepper_top.sv
verif/stepper_angle_microstepper_checker.sv
verif/stepper_angle_microstepper_top_tb.sv
